// ----- src/fre_pkg.sv -----
// Shared types, constants and tables for the frequency response evaluator.
// Used by fre_ctrl, fre_datapath and iir_frequency_response_eval.
`default_nettype none

package fre_pkg;

   localparam int MAX_COEFS_DEF  = 16;
   localparam int COEF_WIDTH_DEF = 24;
   localparam int CORDIC_STEPS   = 16;

   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   // status codes on the result channel
   localparam logic [1:0] RSP_OK   = 2'd0;
   localparam logic [1:0] RSP_ZERO = 2'd1;
   localparam logic [1:0] RSP_SAT  = 2'd2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   // arctangent of 2^-i as a turn fraction, Q0.32 scale (one turn is 2^32)
   function automatic logic signed [33:0] atan_turn(input logic [3:0] i);
      logic signed [33:0] v;
      case (i)
         4'd0:    v = 34'sd536870912;
         4'd1:    v = 34'sd316933406;
         4'd2:    v = 34'sd167458907;
         4'd3:    v = 34'sd85004757;
         4'd4:    v = 34'sd42667335;
         4'd5:    v = 34'sd21354465;
         4'd6:    v = 34'sd10679838;
         4'd7:    v = 34'sd5340245;
         4'd8:    v = 34'sd2670163;
         4'd9:    v = 34'sd1335087;
         4'd10:   v = 34'sd667544;
         4'd11:   v = 34'sd333772;
         4'd12:   v = 34'sd166886;
         4'd13:   v = 34'sd83443;
         4'd14:   v = 34'sd41722;
         4'd15:   v = 34'sd20861;
         default: v = 34'sd0;
      endcase
      return v;
   endfunction

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_CFIN,
      ST_HORNER,
      ST_HSAVE,
      ST_ZCHK,
      ST_NORM_N,
      ST_NORM_D,
      ST_PROD,
      ST_DIVI,
      ST_DSUB,
      ST_DSHIFT,
      ST_DSTORE,
      ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      MS_AR_C,
      MS_AI_S,
      MS_AR_S,
      MS_AI_C,
      MS_NR_DR,
      MS_NI_DI,
      MS_NI_DR,
      MS_NR_DI,
      MS_DR_DR,
      MS_DI_DI
   } msel_type;

   typedef enum logic [1:0] {
      SO_HOLD,
      SO_LOAD,
      SO_SUB
   } sop_type;

   typedef enum logic [2:0] {
      DS_NONE,
      DS_TRE,
      DS_ACC,
      DS_PR,
      DS_PI,
      DS_D2
   } dest_type;

   typedef struct packed {
      logic       coef_wr;
      logic       sel_den;
      logic       acc_clr;
      logic       cordic_init;
      logic       cordic_step;
      logic [3:0] cordic_idx;
      logic       cordic_fin;
      msel_type   msel;
      sop_type    sop;
      dest_type   dest;
      logic       save_num;
      logic       save_den;
      logic       norm_step;
      logic       norm_den;
      logic       div_init;
      logic       div_part;
      logic       div_sub;
      logic       div_shift;
      logic       div_store;
      logic       sat_clr;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic norm_done;
      logic zero_den;
      logic dv_sub_done;
      logic dv_shift_done;
   } stat_type;

endpackage

`default_nettype wire

// ----- src/fre_datapath.sv -----
// Datapath: coefficient stores, CORDIC, shared multiplier, normaliser,
// divider and result registers. Depends on fre_pkg; driven by fre_ctrl.
`default_nettype none

module fre_datapath #(
   parameter int MAX_COEFS  = fre_pkg::MAX_COEFS_DEF,
   parameter int COEF_WIDTH = fre_pkg::COEF_WIDTH_DEF,
   localparam int ADDR_W    = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1
) (
   input  wire logic                clock,
   input  wire fre_pkg::cmd_type    cmd,
   input  wire logic [ADDR_W-1:0]   coef_addr,
   input  wire logic [3:0]          req_coef_index,
   input  wire logic signed [23:0]  req_num_value,
   input  wire logic signed [23:0]  req_den_value,
   input  wire logic [15:0]         req_phase,
   output fre_pkg::stat_type        stat,
   output logic signed [31:0]       rsp_resp_real,
   output logic signed [31:0]       rsp_resp_imag,
   output logic [1:0]               rsp_status
);

   localparam logic signed [32:0] CMAX = (33'sd1 <<< (COEF_WIDTH - 1)) - 33'sd1;
   localparam logic signed [32:0] CMIN = -CMAX - 33'sd1;
   localparam logic [33:0]        LIM  = 34'd2147483648;

   function automatic logic signed [COEF_WIDTH-1:0] clamp_coef(
      input logic signed [23:0] v);
      logic signed [32:0] w;
      w = 33'(v);
      if (w > CMAX) return CMAX[COEF_WIDTH-1:0];
      if (w < CMIN) return CMIN[COEF_WIDTH-1:0];
      return w[COEF_WIDTH-1:0];
   endfunction

   function automatic logic [32:0] mag33(input logic signed [31:0] v);
      logic signed [32:0] w;
      w = 33'(v);
      return w[32] ? 33'(-w) : 33'(w);
   endfunction

   function automatic logic signed [31:0] half_tz(input logic signed [31:0] v);
      logic signed [32:0] w;
      w = 33'(v);
      w = w[32] ? -((-w) >>> 1) : (w >>> 1);
      return w[31:0];
   endfunction

   // coefficient stores
   logic signed [COEF_WIDTH-1:0] num_mem [MAX_COEFS];
   logic signed [COEF_WIDTH-1:0] den_mem [MAX_COEFS];
   logic signed [COEF_WIDTH-1:0] num_rd_ff, den_rd_ff;
   logic [ADDR_W-1:0]            waddr;

   assign waddr = ADDR_W'(req_coef_index);

   always_ff @(posedge clock) begin
      if (cmd.coef_wr && (int'(req_coef_index) < MAX_COEFS)) begin
         num_mem[waddr] <= clamp_coef(req_num_value);
         den_mem[waddr] <= clamp_coef(req_den_value);
      end
      num_rd_ff <= num_mem[coef_addr];
      den_rd_ff <= den_mem[coef_addr];
   end

   logic signed [31:0] coef_ext;
   assign coef_ext = cmd.sel_den ? 32'(den_rd_ff) : 32'(num_rd_ff);

   // CORDIC
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic               flip_ff;
   logic signed [25:0] c_ff, s_ff;
   logic [31:0]        ang;
   logic               flip;
   logic signed [33:0] dx, dy, xf, yf, cx, cy;

   assign ang  = {req_phase, 16'h0000};
   assign flip = ang[31] ^ ang[30];
   assign dx   = y_ff >>> cmd.cordic_idx;
   assign dy   = x_ff >>> cmd.cordic_idx;
   assign xf   = flip_ff ? -x_ff : x_ff;
   assign yf   = flip_ff ? -y_ff : y_ff;
   assign cx   = xf + 34'sd32;
   assign cy   = yf + 34'sd32;

   always_ff @(posedge clock) begin
      if (cmd.cordic_init) begin
         flip_ff <= flip;
         x_ff    <= fre_pkg::CORDIC_GAIN;
         y_ff    <= 34'sd0;
         z_ff    <= 34'(signed'({ang[31] ^ flip, ang[30:0]}));
      end else if (cmd.cordic_step) begin
         if (!z_ff[33]) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - fre_pkg::atan_turn(cmd.cordic_idx);
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + fre_pkg::atan_turn(cmd.cordic_idx);
         end
      end
      if (cmd.cordic_fin) begin
         c_ff <= cx[31:6];
         s_ff <= cy[31:6];
      end
   end

   // shared multiplier and accumulator
   logic signed [31:0] ar_ff, ai_ff, tre_ff;
   logic signed [31:0] nr_ff, ni_ff, dr_ff, di_ff;
   logic signed [31:0] ma, mb, c_ext, s_ext;
   logic signed [63:0] prod_ff, sum_ff, prod_in;
   logic signed [63:0] pr_ff, pi_ff, rs, rsp_sum;
   logic [63:0]        d2_ff;

   assign c_ext = 32'(c_ff);
   assign s_ext = 32'(s_ff);

   always_comb begin
      case (cmd.msel)
         fre_pkg::MS_AR_C:  begin ma = ar_ff; mb = c_ext; end
         fre_pkg::MS_AI_S:  begin ma = ai_ff; mb = s_ext; end
         fre_pkg::MS_AR_S:  begin ma = ar_ff; mb = s_ext; end
         fre_pkg::MS_AI_C:  begin ma = ai_ff; mb = c_ext; end
         fre_pkg::MS_NR_DR: begin ma = nr_ff; mb = dr_ff; end
         fre_pkg::MS_NI_DI: begin ma = ni_ff; mb = di_ff; end
         fre_pkg::MS_NI_DR: begin ma = ni_ff; mb = dr_ff; end
         fre_pkg::MS_NR_DI: begin ma = nr_ff; mb = di_ff; end
         fre_pkg::MS_DR_DR: begin ma = dr_ff; mb = dr_ff; end
         fre_pkg::MS_DI_DI: begin ma = di_ff; mb = di_ff; end
         default:           begin ma = ar_ff; mb = c_ext; end
      endcase
   end

   assign prod_in = ma * mb;
   assign rs      = sum_ff + 64'sd8388608;            // round half up, Q24 -> Q0
   assign rsp_sum = sum_ff + prod_ff + 64'sd8388608;

   // normaliser
   logic signed [31:0] n_re, n_im, n_re2, n_im2;
   logic [32:0]        m_re, m_im, m_max;
   logic               n_big, n_small;
   logic signed [7:0]  en_ff, ed_ff;

   assign n_re    = cmd.norm_den ? dr_ff : nr_ff;
   assign n_im    = cmd.norm_den ? di_ff : ni_ff;
   assign m_re    = mag33(n_re);
   assign m_im    = mag33(n_im);
   assign m_max   = (m_re > m_im) ? m_re : m_im;
   assign n_big   = |m_max[32:30];
   assign n_small = (m_max != 33'd0) && !n_big && !m_max[29];
   assign n_re2   = n_big ? half_tz(n_re) : (n_re <<< 1);
   assign n_im2   = n_big ? half_tz(n_im) : (n_im <<< 1);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (cmd.sop)
         fre_pkg::SO_LOAD: sum_ff <= prod_ff;
         fre_pkg::SO_SUB:  sum_ff <= sum_ff - prod_ff;
         default:          sum_ff <= sum_ff;
      endcase
      if (cmd.acc_clr) begin
         ar_ff <= 32'sd0;
         ai_ff <= 32'sd0;
      end else if (cmd.dest == fre_pkg::DS_ACC) begin
         ar_ff <= tre_ff;
         ai_ff <= rsp_sum[55:24];
      end
      if (cmd.dest == fre_pkg::DS_TRE) tre_ff <= rs[55:24] + coef_ext;
      if (cmd.dest == fre_pkg::DS_PR)  pr_ff  <= sum_ff + prod_ff;
      if (cmd.dest == fre_pkg::DS_PI)  pi_ff  <= sum_ff - prod_ff;
      if (cmd.dest == fre_pkg::DS_D2)  d2_ff  <= 64'(sum_ff + prod_ff);
      if (cmd.sat_clr) begin
         en_ff <= 8'sd0;
         ed_ff <= 8'sd0;
      end
      if (cmd.save_num) begin
         nr_ff <= ar_ff;
         ni_ff <= ai_ff;
      end
      if (cmd.save_den) begin
         dr_ff <= ar_ff;
         di_ff <= ai_ff;
      end
      if (cmd.norm_step && (n_big || n_small)) begin
         if (cmd.norm_den) begin
            dr_ff <= n_re2;
            di_ff <= n_im2;
            ed_ff <= n_big ? ed_ff + 8'sd1 : ed_ff - 8'sd1;
         end else begin
            nr_ff <= n_re2;
            ni_ff <= n_im2;
            en_ff <= n_big ? en_ff + 8'sd1 : en_ff - 8'sd1;
         end
      end
   end

   // divider: quotient integer part by subtraction, then one bit per cycle
   logic [63:0]        rem_ff;
   logic [33:0]        q_ff;
   logic signed [7:0]  ecnt_ff;
   logic               dneg_ff, sat_ff;
   logic signed [31:0] hr_ff, hi_ff;
   logic signed [63:0] p_sel;
   logic [64:0]        r2, r2d;
   logic [33:0]        q2, qs, qneg;
   logic               q_sat;
   logic [7:0]         rsh;

   assign p_sel = cmd.div_part ? pi_ff : pr_ff;
   assign r2    = {rem_ff, 1'b0};
   assign r2d   = r2 - {1'b0, d2_ff};
   assign q2    = {q_ff[32:0], 1'b0};
   assign rsh   = 8'(-ecnt_ff);
   assign q_sat = dneg_ff ? (q_ff > LIM) : (q_ff > LIM - 34'd1);
   assign qs    = q_sat ? (dneg_ff ? LIM : LIM - 34'd1) : q_ff;
   assign qneg  = 34'd0 - qs;

   always_ff @(posedge clock) begin
      if (cmd.sat_clr) sat_ff <= 1'b0;
      if (cmd.div_init) begin
         dneg_ff <= p_sel[63];
         rem_ff  <= p_sel[63] ? 64'(-p_sel) : 64'(p_sel);
         q_ff    <= 34'd0;
         ecnt_ff <= 8'sd16 + en_ff - ed_ff;
      end else if (cmd.div_sub) begin
         if (rem_ff >= d2_ff) begin
            rem_ff <= rem_ff - d2_ff;
            q_ff   <= q_ff + 34'd1;
         end
      end else if (cmd.div_shift) begin
         if (ecnt_ff[7]) begin
            q_ff    <= q_ff >> rsh;
            ecnt_ff <= 8'sd0;
         end else if ((ecnt_ff != 8'sd0) && (q_ff <= LIM)) begin
            if (r2 >= {1'b0, d2_ff}) begin
               rem_ff <= r2d[63:0];
               q_ff   <= q2 + 34'd1;
            end else begin
               rem_ff <= r2[63:0];
               q_ff   <= q2;
            end
            ecnt_ff <= ecnt_ff - 8'sd1;
         end
      end
      if (cmd.div_store) begin
         if (q_sat) sat_ff <= 1'b1;
         if (cmd.div_part) hi_ff <= dneg_ff ? qneg[31:0] : qs[31:0];
         else              hr_ff <= dneg_ff ? qneg[31:0] : qs[31:0];
      end
      if (cmd.out_load) begin
         if (stat.zero_den) begin
            rsp_resp_real <= 32'sd0;
            rsp_resp_imag <= 32'sd0;
            rsp_status    <= fre_pkg::RSP_ZERO;
         end else begin
            rsp_resp_real <= hr_ff;
            rsp_resp_imag <= hi_ff;
            rsp_status    <= sat_ff ? fre_pkg::RSP_SAT : fre_pkg::RSP_OK;
         end
      end
   end

   assign stat.norm_done     = !(n_big || n_small);
   assign stat.zero_den      = (dr_ff == 32'sd0) && (di_ff == 32'sd0);
   assign stat.dv_sub_done   = rem_ff < d2_ff;
   assign stat.dv_shift_done = !ecnt_ff[7] && ((ecnt_ff == 8'sd0) || (q_ff > LIM));

endmodule

`default_nettype wire

// ----- src/fre_ctrl.sv -----
// Sequencer: order register, handshakes and the command schedule.
// Depends on fre_pkg; commands fre_datapath.
`default_nettype none

module fre_ctrl #(
   parameter int MAX_COEFS = fre_pkg::MAX_COEFS_DEF,
   localparam int ADDR_W   = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_op,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [3:0]        csr_filter_order,
   input  wire fre_pkg::stat_type stat,
   output fre_pkg::cmd_type       cmd,
   output logic [ADDR_W-1:0]      coef_addr
);

   fre_pkg::state_type state_ff, state_in;
   logic [3:0]        order_ff;
   logic [ADDR_W-1:0] k_ff, k_in, n_eff;
   logic [2:0]        ph_ff, ph_in;
   logic [3:0]        it_ff, it_in;
   logic              den_ff, den_in, part_ff, part_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != fre_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign coef_addr = k_ff;
   assign n_eff     = (int'(order_ff) < MAX_COEFS) ? ADDR_W'(order_ff)
                                                   : ADDR_W'(MAX_COEFS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fre_pkg::ST_IDLE;
         order_ff     <= 4'd0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         ph_ff        <= 3'd0;
         it_ff        <= 4'd0;
         den_ff       <= 1'b0;
         part_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         ph_ff        <= ph_in;
         it_ff        <= it_in;
         den_ff       <= den_in;
         part_ff      <= part_in;
         if (csr_valid && csr_ready) order_ff <= csr_filter_order;
      end
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      ph_in        = ph_ff;
      it_in        = it_ff;
      den_in       = den_ff;
      part_in      = part_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.sel_den  = den_ff;
      cmd.cordic_idx = it_ff;
      cmd.msel     = fre_pkg::MS_AR_C;
      cmd.sop      = fre_pkg::SO_HOLD;
      cmd.dest     = fre_pkg::DS_NONE;
      cmd.div_part = part_ff;
      case (state_ff)
         fre_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_op == fre_pkg::OP_LOAD) begin
                  cmd.coef_wr = 1'b1;
               end else begin
                  cmd.cordic_init = 1'b1;
                  cmd.sat_clr     = 1'b1;
                  it_in           = 4'd0;
                  state_in        = fre_pkg::ST_CORDIC;
               end
            end
         end
         fre_pkg::ST_CORDIC: begin
            cmd.cordic_step = 1'b1;
            it_in = it_ff + 4'd1;
            if (it_ff == 4'(fre_pkg::CORDIC_STEPS - 1)) state_in = fre_pkg::ST_CFIN;
         end
         fre_pkg::ST_CFIN: begin
            cmd.cordic_fin = 1'b1;
            cmd.acc_clr    = 1'b1;
            k_in     = '0;
            ph_in    = 3'd0;
            den_in   = 1'b0;
            state_in = fre_pkg::ST_HORNER;
         end
         fre_pkg::ST_HORNER: begin
            ph_in = ph_ff + 3'd1;
            case (ph_ff)
               3'd0: cmd.msel = fre_pkg::MS_AR_C;
               3'd1: begin
                  cmd.sop  = fre_pkg::SO_LOAD;
                  cmd.msel = fre_pkg::MS_AI_S;
               end
               3'd2: begin
                  cmd.sop  = fre_pkg::SO_SUB;
                  cmd.msel = fre_pkg::MS_AR_S;
               end
               3'd3: begin
                  cmd.dest = fre_pkg::DS_TRE;
                  cmd.sop  = fre_pkg::SO_LOAD;
                  cmd.msel = fre_pkg::MS_AI_C;
               end
               default: begin
                  cmd.dest = fre_pkg::DS_ACC;
                  ph_in    = 3'd0;
                  if (k_ff == n_eff) state_in = fre_pkg::ST_HSAVE;
                  else               k_in = k_ff + ADDR_W'(1);
               end
            endcase
         end
         fre_pkg::ST_HSAVE: begin
            if (!den_ff) begin
               cmd.save_num = 1'b1;
               cmd.acc_clr  = 1'b1;
               den_in   = 1'b1;
               k_in     = '0;
               ph_in    = 3'd0;
               state_in = fre_pkg::ST_HORNER;
            end else begin
               cmd.save_den = 1'b1;
               state_in = fre_pkg::ST_ZCHK;
            end
         end
         fre_pkg::ST_ZCHK: begin
            state_in = stat.zero_den ? fre_pkg::ST_OUT : fre_pkg::ST_NORM_N;
         end
         fre_pkg::ST_NORM_N: begin
            cmd.norm_step = 1'b1;
            if (stat.norm_done) state_in = fre_pkg::ST_NORM_D;
         end
         fre_pkg::ST_NORM_D: begin
            cmd.norm_step = 1'b1;
            cmd.norm_den  = 1'b1;
            ph_in = 3'd0;
            if (stat.norm_done) state_in = fre_pkg::ST_PROD;
         end
         fre_pkg::ST_PROD: begin
            ph_in = ph_ff + 3'd1;
            case (ph_ff)
               3'd0: cmd.msel = fre_pkg::MS_NR_DR;
               3'd1: begin
                  cmd.sop  = fre_pkg::SO_LOAD;
                  cmd.msel = fre_pkg::MS_NI_DI;
               end
               3'd2: begin
                  cmd.dest = fre_pkg::DS_PR;
                  cmd.msel = fre_pkg::MS_NI_DR;
               end
               3'd3: begin
                  cmd.sop  = fre_pkg::SO_LOAD;
                  cmd.msel = fre_pkg::MS_NR_DI;
               end
               3'd4: begin
                  cmd.dest = fre_pkg::DS_PI;
                  cmd.msel = fre_pkg::MS_DR_DR;
               end
               3'd5: begin
                  cmd.sop  = fre_pkg::SO_LOAD;
                  cmd.msel = fre_pkg::MS_DI_DI;
               end
               default: begin
                  cmd.dest = fre_pkg::DS_D2;
                  ph_in    = 3'd0;
                  part_in  = 1'b0;
                  state_in = fre_pkg::ST_DIVI;
               end
            endcase
         end
         fre_pkg::ST_DIVI: begin
            cmd.div_init = 1'b1;
            state_in = fre_pkg::ST_DSUB;
         end
         fre_pkg::ST_DSUB: begin
            cmd.div_sub = 1'b1;
            if (stat.dv_sub_done) state_in = fre_pkg::ST_DSHIFT;
         end
         fre_pkg::ST_DSHIFT: begin
            cmd.div_shift = 1'b1;
            if (stat.dv_shift_done) state_in = fre_pkg::ST_DSTORE;
         end
         fre_pkg::ST_DSTORE: begin
            cmd.div_store = 1'b1;
            if (!part_ff) begin
               part_in  = 1'b1;
               state_in = fre_pkg::ST_DIVI;
            end else begin
               state_in = fre_pkg::ST_OUT;
            end
         end
         fre_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = fre_pkg::ST_IDLE;
            end
         end
         default: state_in = fre_pkg::ST_IDLE;
      endcase
   end

   a_eval_start: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == fre_pkg::OP_EVAL)) |=> (state_ff == fre_pkg::ST_CORDIC))
      else $error("evaluate request did not start the CORDIC");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fre_pkg::ST_OUT && rsp_valid_ff && rsp_stall)
      |=> (state_ff == fre_pkg::ST_OUT))
      else $error("pending result overwritten");

   a_k_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fre_pkg::ST_HORNER) |-> (k_ff <= n_eff))
      else $error("coefficient index beyond order");

   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fre_pkg::ST_DSTORE && part_ff) |=> (state_ff == fre_pkg::ST_OUT))
      else $error("divide sequence did not finish");

endmodule

`default_nettype wire

// ----- src/iir_frequency_response_eval.sv -----
// Top level of the filter frequency response evaluator.
// Depends on fre_pkg, fre_ctrl and fre_datapath.
`default_nettype none

// Evaluates H(e^jw) = A/B for a filter held as up to MAX_COEFS numerator and
// denominator coefficient pairs (signed Q3.20). A load request (op 0) writes
// pair k. An evaluate request (op 1) takes the phase as a 16-bit fraction of
// a turn and returns one result: real and imaginary parts in Q15.16,
// truncated toward zero and clamped, with status 0 ok, 1 zero denominator
// (result zero) or 2 saturated. An evaluation runs the CORDIC, the two Horner
// sums, the normalising of A and B (one bit a cycle), the products and, per
// quotient part, the subtract steps and the divider's result bits, one per
// cycle. The single shared 32x32 multiplier (four products per Horner step)
// and the bit-serial divider set the evaluation time. filter_order must be
// written by the user through the csr port only while the block is idle;
// the block itself does not enforce this. The coefficient stores come up
// unwritten and need no clearing.
module iir_frequency_response_eval #(
   parameter int MAX_COEFS  = fre_pkg::MAX_COEFS_DEF,
   parameter int COEF_WIDTH = fre_pkg::COEF_WIDTH_DEF,
   localparam int ADDR_W    = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_op,
   input  wire logic [3:0]         req_coef_index,
   input  wire logic signed [23:0] req_num_value,
   input  wire logic signed [23:0] req_den_value,
   input  wire logic [15:0]        req_phase,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_resp_real,
   output logic signed [31:0]      rsp_resp_imag,
   output logic [1:0]              rsp_status,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [3:0]         csr_filter_order
);

   fre_pkg::cmd_type  cmd;
   fre_pkg::stat_type stat;
   logic [ADDR_W-1:0] coef_addr;

   // sequencer: owns the handshakes and the order register
   fre_ctrl #(
      .MAX_COEFS (MAX_COEFS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_filter_order (csr_filter_order),
      .stat             (stat),
      .cmd              (cmd),
      .coef_addr        (coef_addr)
   );

   // arithmetic, stores and the result register
   fre_datapath #(
      .MAX_COEFS  (MAX_COEFS),
      .COEF_WIDTH (COEF_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .coef_addr      (coef_addr),
      .req_coef_index (req_coef_index),
      .req_num_value  (req_num_value),
      .req_den_value  (req_den_value),
      .req_phase      (req_phase),
      .stat           (stat),
      .rsp_resp_real  (rsp_resp_real),
      .rsp_resp_imag  (rsp_resp_imag),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire
